[sv/anagram_histogram_matcher_top_assert.svh]
// Assertion macros used by the matcher datapath module. The clock and reset of the
// module that uses them are taken by their names, clock and reset.
`ifndef ANAGRAM_HISTOGRAM_MATCHER_TOP_ASSERT_SVH
`define ANAGRAM_HISTOGRAM_MATCHER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AHM_ASSERT_HOLDS(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("%m: property violated");

// The consequent must hold in the cycle after the antecedent.
`define AHM_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m: property violated");

`endif

[sv/ahm_pkg.sv]
package ahm_pkg;

   localparam int DICT_WORDS = 256;
   localparam int COUNT_BITS = 8;
   localparam int LETTERS    = 26;
   localparam int IDX_W      = 5;
   localparam int MATCH_W    = 9;
   localparam int HIST_W     = LETTERS * COUNT_BITS;
   localparam int CNT_W      = $clog2(DICT_WORDS + 1);
   localparam int ADDR_W     = (DICT_WORDS > 1) ? $clog2(DICT_WORDS) : 1;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   localparam logic [7:0] LEAD_BYTE = 8'hC3;
   localparam logic [7:0] UPPER_A   = 8'h41;
   localparam logic [7:0] UPPER_Z   = 8'h5A;
   localparam logic [7:0] LOWER_A   = 8'h61;
   localparam logic [7:0] LOWER_Z   = 8'h7A;

   localparam logic [IDX_W-1:0] IDX_A = 5'd0;
   localparam logic [IDX_W-1:0] IDX_E = 5'd4;
   localparam logic [IDX_W-1:0] IDX_I = 5'd8;
   localparam logic [IDX_W-1:0] IDX_O = 5'd14;
   localparam logic [IDX_W-1:0] IDX_U = 5'd20;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_QUERY = 2'd1,
      OP_CLEAR = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STORE,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic fold_en;
      logic word_clr;
      logic dict_clr;
      logic store_en;
      logic scan_init;
      logic scan_run;
      logic rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic rsp_free;
   } dp_status_type;

   typedef struct packed {
      logic             hit;
      logic [IDX_W-1:0] idx;
   } letter_type;

   // Second byte of a two-byte accented vowel, mapped to its plain letter.
   function automatic letter_type accent_letter(input logic [7:0] b);
      letter_type l;
      l.hit = 1'b1;
      l.idx = IDX_A;
      case (b)
         8'hA1, 8'h81: l.idx = IDX_A;
         8'hA9, 8'h89: l.idx = IDX_E;
         8'hAD, 8'h8D: l.idx = IDX_I;
         8'hB3, 8'h93: l.idx = IDX_O;
         8'hBA, 8'h9A: l.idx = IDX_U;
         default:      l.hit = 1'b0;
      endcase
      return l;
   endfunction

endpackage

[sv/ahm_req_if.sv]
interface ahm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [7:0] byte_value;
   logic       last_byte;

   modport source (output valid, output opcode, output byte_value, output last_byte,
                   input ready);
   modport sink (input valid, input opcode, input byte_value, input last_byte,
                 output ready);
endinterface

[sv/ahm_rsp_if.sv]
interface ahm_rsp_if;
   logic       valid;
   logic       ready;
   logic [8:0] match_count;

   modport source (output valid, output match_count, input ready);
   modport sink (input valid, input match_count, output ready);
endinterface

[sv/anagram_histogram_matcher_top.sv]
// Load and query bytes are accepted while idle; after a load word's last byte, a
// store state takes no requests while the word is written. A query's last byte
// starts a walk of the dictionary, one stored entry per cycle: the count is
// registered once every stored word has been compared; requests wait until then
// and longer while the output register is still full. Clears are taken while idle.
// Synchronous reset empties the dictionary and the word; the memory is not swept.
module anagram_histogram_matcher_top (
   input logic       clock,
   input logic       reset,
   ahm_req_if.sink   req_chan,
   ahm_rsp_if.source rsp_chan
);

   ahm_pkg::dp_cmd_type    cmd;
   ahm_pkg::dp_status_type status;

   ahm_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_opcode (req_chan.opcode),
      .req_last   (req_chan.last_byte),
      .req_ready  (req_chan.ready),
      .status     (status),
      .cmd        (cmd)
   );

   ahm_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .byte_value  (req_chan.byte_value),
      .last_byte   (req_chan.last_byte),
      .rsp_ready   (rsp_chan.ready),
      .rsp_valid   (rsp_chan.valid),
      .match_count (rsp_chan.match_count)
   );

endmodule

[sv/ahm_ram.sv]
module ahm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/ahm_controller.sv]
module ahm_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [1:0]             req_opcode,
   input  logic                   req_last,
   output logic                   req_ready,
   input  ahm_pkg::dp_status_type status,
   output ahm_pkg::dp_cmd_type    cmd
);

   ahm_pkg::state_type state_ff;
   ahm_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ahm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ahm_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_opcode)
                  ahm_pkg::OP_LOAD: begin
                     cmd.fold_en = 1'b1;
                     if (req_last) begin
                        state_in = ahm_pkg::ST_STORE;
                     end
                  end
                  ahm_pkg::OP_QUERY: begin
                     cmd.fold_en = 1'b1;
                     if (req_last) begin
                        cmd.scan_init = 1'b1;
                        state_in      = ahm_pkg::ST_SCAN;
                     end
                  end
                  ahm_pkg::OP_CLEAR: begin
                     cmd.dict_clr = 1'b1;
                     cmd.word_clr = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         ahm_pkg::ST_STORE: begin
            cmd.store_en = 1'b1;
            cmd.word_clr = 1'b1;
            state_in     = ahm_pkg::ST_IDLE;
         end
         ahm_pkg::ST_SCAN: begin
            cmd.scan_run = 1'b1;
            // The result waits here until the output register has room.
            if (status.scan_done && status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               cmd.word_clr = 1'b1;
               state_in     = ahm_pkg::ST_IDLE;
            end
         end
         default: state_in = ahm_pkg::ST_IDLE;
      endcase
   end

endmodule

[sv/ahm_datapath.sv]
module ahm_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  ahm_pkg::dp_cmd_type                 cmd,
   output ahm_pkg::dp_status_type              status,
   input  logic [7:0]                          byte_value,
   input  logic                                last_byte,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [ahm_pkg::MATCH_W-1:0]         match_count
);

   `include "anagram_histogram_matcher_top_assert.svh"

   logic                             lead_ff;
   logic                             lead_in;
   logic [ahm_pkg::COUNT_BITS-1:0]   hist_ff [ahm_pkg::LETTERS];
   logic [ahm_pkg::COUNT_BITS-1:0]   hist_in [ahm_pkg::LETTERS];
   logic [ahm_pkg::HIST_W-1:0]       hist_vec;
   logic [ahm_pkg::CNT_W-1:0]        dict_cnt_ff;
   logic [ahm_pkg::CNT_W-1:0]        dict_cnt_in;
   logic [ahm_pkg::CNT_W-1:0]        scan_addr_ff;
   logic [ahm_pkg::CNT_W-1:0]        scan_addr_in;
   logic [ahm_pkg::CNT_W-1:0]        match_ff;
   logic [ahm_pkg::CNT_W-1:0]        match_in;
   logic                             rdv_ff;
   logic                             rdv_in;
   logic                             rsp_valid_ff;
   logic                             rsp_valid_in;
   logic [ahm_pkg::MATCH_W-1:0]      rsp_data_ff;
   logic [ahm_pkg::HIST_W-1:0]       ram_q;
   logic                             dict_full;
   logic                             dict_wr;
   logic                             scan_issue;
   ahm_pkg::letter_type              letter;
   logic [7:0]                       upper_off;
   logic [7:0]                       lower_off;

   // Byte folding: one letter index per accepted byte, or none.
   always_comb begin
      letter    = '0;
      lead_in   = lead_ff;
      upper_off = byte_value - ahm_pkg::UPPER_A;
      lower_off = byte_value - ahm_pkg::LOWER_A;
      if (cmd.fold_en) begin
         if (lead_ff) begin
            lead_in = 1'b0;
            letter  = ahm_pkg::accent_letter(byte_value);
         end else if (byte_value == ahm_pkg::LEAD_BYTE) begin
            lead_in = 1'b1;
         end else if (byte_value >= ahm_pkg::UPPER_A && byte_value <= ahm_pkg::UPPER_Z) begin
            letter.hit = 1'b1;
            letter.idx = upper_off[ahm_pkg::IDX_W-1:0];
         end else if (byte_value >= ahm_pkg::LOWER_A && byte_value <= ahm_pkg::LOWER_Z) begin
            letter.hit = 1'b1;
            letter.idx = lower_off[ahm_pkg::IDX_W-1:0];
         end
         // A lead byte still open at the end of a word is dropped.
         if (last_byte) begin
            lead_in = 1'b0;
         end
      end
      if (cmd.word_clr) begin
         lead_in = 1'b0;
      end
   end

   always_comb begin
      for (int i = 0; i < ahm_pkg::LETTERS; i++) begin
         hist_in[i] = hist_ff[i];
         if (cmd.word_clr) begin
            hist_in[i] = '0;
         end else if (letter.hit && letter.idx == ahm_pkg::IDX_W'(i)
                      && hist_ff[i] != ahm_pkg::COUNT_MAX) begin
            hist_in[i] = hist_ff[i] + 1'b1;
         end
         hist_vec[i*ahm_pkg::COUNT_BITS +: ahm_pkg::COUNT_BITS] = hist_ff[i];
      end
   end

   assign dict_full  = (dict_cnt_ff == ahm_pkg::CNT_W'(ahm_pkg::DICT_WORDS));
   assign dict_wr    = cmd.store_en && !dict_full;
   assign scan_issue = cmd.scan_run && (scan_addr_ff != dict_cnt_ff);

   always_comb begin
      dict_cnt_in = dict_cnt_ff;
      if (cmd.dict_clr) begin
         dict_cnt_in = '0;
      end else if (dict_wr) begin
         dict_cnt_in = dict_cnt_ff + 1'b1;
      end

      scan_addr_in = scan_addr_ff;
      rdv_in       = 1'b0;
      match_in     = match_ff;
      if (cmd.scan_init) begin
         scan_addr_in = '0;
         match_in     = '0;
      end else begin
         if (scan_issue) begin
            scan_addr_in = scan_addr_ff + 1'b1;
            rdv_in       = 1'b1;
         end
         // Entry data arrives in the cycle after its address.
         if (rdv_ff && ram_q == hist_vec) begin
            match_in = match_ff + 1'b1;
         end
      end

      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_ff      <= 1'b0;
         dict_cnt_ff  <= '0;
         scan_addr_ff <= '0;
         match_ff     <= '0;
         rdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ahm_pkg::LETTERS; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         lead_ff      <= lead_in;
         dict_cnt_ff  <= dict_cnt_in;
         scan_addr_ff <= scan_addr_in;
         match_ff     <= match_in;
         rdv_ff       <= rdv_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < ahm_pkg::LETTERS; i++) begin
            hist_ff[i] <= hist_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_data_ff <= ahm_pkg::MATCH_W'(match_ff);
      end
   end

   ahm_ram #(
      .WIDTH (ahm_pkg::HIST_W),
      .DEPTH (ahm_pkg::DICT_WORDS)
   ) u_dict_ram (
      .clock   (clock),
      .wr_en   (dict_wr),
      .wr_addr (dict_cnt_ff[ahm_pkg::ADDR_W-1:0]),
      .wr_data (hist_vec),
      .rd_addr (scan_addr_ff[ahm_pkg::ADDR_W-1:0]),
      .rd_data (ram_q)
   );

   assign status.scan_done = !rdv_ff && (scan_addr_ff == dict_cnt_ff);
   assign status.rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign match_count      = rsp_data_ff;

   `AHM_ASSERT_NEXT(a_store_grows, dict_wr && !cmd.dict_clr,
                    dict_cnt_ff == ahm_pkg::CNT_W'($past(dict_cnt_ff) + 1'b1))
   `AHM_ASSERT_HOLDS(a_scan_in_range, cmd.scan_run, scan_addr_ff <= dict_cnt_ff)
   `AHM_ASSERT_HOLDS(a_match_bounded, 1'b1, match_ff <= scan_addr_ff)
   `AHM_ASSERT_HOLDS(a_read_issued, rdv_ff, scan_addr_ff != '0)

endmodule

[tb/tb_anagram_histogram_matcher_top.sv]
`timescale 1ns / 100ps

module tb_anagram_histogram_matcher_top;

   // The opcode value that the block ignores.
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 1050;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] byte_val;
      logic       last_byte;
      logic       wait_idle;
   } req_item_type;

   typedef struct packed {
      logic [3:0]       len;
      logic [15:0][4:0] letter;
   } word_spec_type;

   logic clock;
   logic reset;

   ahm_req_if req_chan();
   ahm_rsp_if rsp_chan();

   anagram_histogram_matcher_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   req_item_type req_queue[$];
   int           stim_items;

   // Mirror of the block: word in progress and stored histograms.
   logic [ahm_pkg::LETTERS-1:0][ahm_pkg::COUNT_BITS-1:0] word_hist;
   logic                                                 lead_seen;
   logic [ahm_pkg::LETTERS-1:0][ahm_pkg::COUNT_BITS-1:0] dict_hist [ahm_pkg::DICT_WORDS];
   int                                                   dict_size;
   logic [ahm_pkg::MATCH_W-1:0]                          match_due[$];
   int                                                   queries_accepted;

   int   fail_count;
   logic req_fire;
   int   burst_left;
   int   gap_left;
   int   hold_left;
   bit   hold_done;
   int   stall_mode;
   int   mode_left;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int vowel_of(input logic [7:0] tail);
      case (tail)
         8'hA1, 8'h81: return int'(ahm_pkg::IDX_A);
         8'hA9, 8'h89: return int'(ahm_pkg::IDX_E);
         8'hAD, 8'h8D: return int'(ahm_pkg::IDX_I);
         8'hB3, 8'h93: return int'(ahm_pkg::IDX_O);
         8'hBA, 8'h9A: return int'(ahm_pkg::IDX_U);
         default:      return -1;
      endcase
   endfunction

   function automatic logic [7:0] accent_tail(input logic [4:0] l);
      case (l)
         ahm_pkg::IDX_A: return 8'hA1;
         ahm_pkg::IDX_E: return 8'hA9;
         ahm_pkg::IDX_I: return 8'hAD;
         ahm_pkg::IDX_O: return 8'hB3;
         ahm_pkg::IDX_U: return 8'hBA;
         default:        return 8'h00;
      endcase
   endfunction

   task automatic fold_and_count(input logic [1:0] op, input logic [7:0] b,
                                 input logic last_byte);
      int                          idx;
      int                          k;
      logic [ahm_pkg::MATCH_W-1:0] hits;
      idx = -1;
      if (op == ahm_pkg::OP_CLEAR) begin
         dict_size = 0;
         lead_seen = 1'b0;
         word_hist = '0;
      end else if (op == ahm_pkg::OP_LOAD || op == ahm_pkg::OP_QUERY) begin
         if (lead_seen) begin
            lead_seen = 1'b0;
            idx = vowel_of(b);
         end else if (b == ahm_pkg::LEAD_BYTE) begin
            lead_seen = 1'b1;
         end else if (b >= ahm_pkg::UPPER_A && b <= ahm_pkg::UPPER_Z) begin
            idx = int'(b - ahm_pkg::UPPER_A);
         end else if (b >= ahm_pkg::LOWER_A && b <= ahm_pkg::LOWER_Z) begin
            idx = int'(b - ahm_pkg::LOWER_A);
         end
         if (idx >= 0 && word_hist[idx] != ahm_pkg::COUNT_MAX) begin
            word_hist[idx] = word_hist[idx] + 1'b1;
         end
         if (last_byte) begin
            if (op == ahm_pkg::OP_LOAD) begin
               if (dict_size < ahm_pkg::DICT_WORDS) begin
                  dict_hist[dict_size] = word_hist;
                  dict_size++;
               end
            end else begin
               hits = '0;
               for (k = 0; k < dict_size; k++) begin
                  if (dict_hist[k] == word_hist) hits = hits + 1'b1;
               end
               match_due.push_back(hits);
               queries_accepted++;
            end
            lead_seen = 1'b0;
            word_hist = '0;
         end
      end
   endtask

   task automatic push_req(input logic [1:0] op, input logic [7:0] b,
                           input logic last_byte, input logic wait_idle);
      req_item_type it;
      it.op = op;
      it.byte_val = b;
      it.last_byte = last_byte;
      it.wait_idle = wait_idle;
      req_queue.push_back(it);
      if (op != OP_UNUSED) stim_items++;
   endtask

   function automatic logic [7:0] filler_byte();
      logic [7:0] b;
      do begin
         b = 8'($urandom_range(0, 255));
      end while ((b >= ahm_pkg::UPPER_A && b <= ahm_pkg::UPPER_Z) ||
                 (b >= ahm_pkg::LOWER_A && b <= ahm_pkg::LOWER_Z) ||
                 b == ahm_pkg::LEAD_BYTE);
      return b;
   endfunction

   function automatic word_spec_type random_word();
      word_spec_type w;
      int            top;
      int            i;
      // A narrow alphabet most of the time, so that queries hit stored words.
      top = ($urandom_range(0, 2) == 0) ? ahm_pkg::LETTERS - 1 : $urandom_range(1, 5);
      w.len = ($urandom_range(0, 11) == 0) ? 4'd0 : 4'($urandom_range(1, 12));
      for (i = 0; i < 16; i++) w.letter[i] = 5'($urandom_range(0, top));
      return w;
   endfunction

   // Spells the letters of w in random order, case and accent form, with some
   // noise bytes. Two spellings of the same word are anagrams unless a noise pair forms an accented vowel.
   task automatic spell_word(input word_spec_type w, input logic [1:0] op,
                             input bit finish, input logic wait_idle);
      logic [4:0] pool[$];
      logic [7:0] seq[$];
      logic [7:0] tail;
      logic [4:0] l;
      logic [1:0] byte_op;
      bit         up;
      int         i;
      int         j;
      for (i = 0; i < int'(w.len); i++) pool.push_back(w.letter[i]);
      while (pool.size() > 0) begin
         j = $urandom_range(0, pool.size() - 1);
         l = pool[j];
         pool.delete(j);
         case ($urandom_range(0, 11))
            0: seq.push_back(filler_byte());
            1: begin
               seq.push_back(ahm_pkg::LEAD_BYTE);
               seq.push_back(8'($urandom_range(0, 255)));
            end
            default: ;
         endcase
         up = ($urandom_range(0, 1) != 0);
         tail = accent_tail(l);
         if (tail != 8'h00 && $urandom_range(0, 2) == 0) begin
            seq.push_back(ahm_pkg::LEAD_BYTE);
            seq.push_back(tail - (up ? 8'h20 : 8'h00));
         end else begin
            seq.push_back((up ? ahm_pkg::UPPER_A : ahm_pkg::LOWER_A) + 8'(l));
         end
      end
      if (finish && $urandom_range(0, 9) == 0) seq.push_back(ahm_pkg::LEAD_BYTE);
      if (seq.size() == 0) seq.push_back(filler_byte());
      for (i = 0; i < seq.size(); i++) begin
         byte_op = op;
         if (i + 1 < seq.size() && $urandom_range(0, 15) == 0) begin
            byte_op = (op == ahm_pkg::OP_LOAD) ? ahm_pkg::OP_QUERY : ahm_pkg::OP_LOAD;
         end
         if ($urandom_range(0, 39) == 0) begin
            push_req(OP_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                     1'b0);
         end
         push_req(byte_op, seq[i], finish && (i + 1 == seq.size()), wait_idle && (i == 0));
      end
   endtask

   // Request driver: bursts of random length separated by random gaps.
   always @(negedge clock) begin : request_driver
      req_item_type nxt;
      if (!reset && (!req_chan.valid || req_fire)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_chan.valid <= 1'b0;
         end else if (req_queue.size() > 0 &&
                      !(req_queue[0].wait_idle && match_due.size() > 0)) begin
            nxt = req_queue.pop_front();
            req_chan.valid <= 1'b1;
            req_chan.opcode <= nxt.op;
            req_chan.byte_value <= nxt.byte_val;
            req_chan.last_byte <= nxt.last_byte;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left--;
            end
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Result receiver: stall patterns that change now and then, and one long
   // hold-off once enough queries are in, so that the block backs up.
   always @(negedge clock) begin : result_receiver
      if (!reset) begin
         if (!hold_done && queries_accepted >= 20) begin
            hold_done = 1'b1;
            hold_left = 2000;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            if (mode_left <= 0) begin
               stall_mode = $urandom_range(0, 2);
               mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (stall_mode)
               0:       rsp_chan.ready <= 1'b1;
               1:       rsp_chan.ready <= 1'($urandom_range(0, 1));
               default: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin : monitor
      logic [ahm_pkg::MATCH_W-1:0] want;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_chan.valid && req_chan.ready;
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (match_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("match count %0d returned with no query waiting",
                           rsp_chan.match_count);
               end
            end else begin
               want = match_due.pop_front();
               if (rsp_chan.match_count !== want) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("match count mismatch: expected %0d, got %0d",
                              want, rsp_chan.match_count);
                  end
               end
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            fold_and_count(req_chan.opcode, req_chan.byte_value, req_chan.last_byte);
         end
      end
   end

   initial begin : stimulus
      word_spec_type bank[8];
      word_spec_type w;
      int            nbank;
      int            dict_est;
      int            k;
      logic          hold;
      bit            full_done;
      bit            sat_done;

      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.opcode = ahm_pkg::OP_LOAD;
      req_chan.byte_value = 8'h00;
      req_chan.last_byte = 1'b0;
      rsp_chan.ready = 1'b0;
      stim_items = 0;
      word_hist = '0;
      lead_seen = 1'b0;
      dict_size = 0;
      queries_accepted = 0;
      fail_count = 0;
      burst_left = 0;
      gap_left = 0;
      hold_left = 0;
      hold_done = 1'b0;
      stall_mode = 0;
      mode_left = 0;
      dict_est = 0;
      full_done = 1'b0;
      sat_done = 1'b0;

      // Both ends of the letter ranges, plain and accented, as anagrams.
      push_req(ahm_pkg::OP_LOAD, ahm_pkg::UPPER_A, 1'b0, 1'b0);
      push_req(ahm_pkg::OP_LOAD, ahm_pkg::LOWER_Z, 1'b1, 1'b0);
      push_req(ahm_pkg::OP_LOAD, ahm_pkg::UPPER_Z, 1'b0, 1'b0);
      push_req(ahm_pkg::OP_LOAD, ahm_pkg::LEAD_BYTE, 1'b0, 1'b0);
      push_req(ahm_pkg::OP_LOAD, 8'h81, 1'b1, 1'b0);
      push_req(ahm_pkg::OP_QUERY, ahm_pkg::LOWER_A, 1'b0, 1'b0);
      push_req(ahm_pkg::OP_QUERY, ahm_pkg::UPPER_Z, 1'b1, 1'b0);
      // Bytes just outside the letter ranges, an unknown accent pair and a
      // lead byte at the end: the query word is empty.
      push_req(ahm_pkg::OP_QUERY, 8'h40, 1'b0, 1'b0);
      push_req(ahm_pkg::OP_QUERY, 8'h5B, 1'b0, 1'b0);
      push_req(ahm_pkg::OP_QUERY, 8'h60, 1'b0, 1'b0);
      push_req(ahm_pkg::OP_QUERY, 8'h7B, 1'b0, 1'b0);
      push_req(ahm_pkg::OP_QUERY, ahm_pkg::LEAD_BYTE, 1'b0, 1'b0);
      push_req(ahm_pkg::OP_QUERY, ahm_pkg::LEAD_BYTE, 1'b0, 1'b0);
      push_req(ahm_pkg::OP_QUERY, 8'hFF, 1'b0, 1'b0);
      push_req(ahm_pkg::OP_QUERY, 8'h00, 1'b0, 1'b0);
      push_req(ahm_pkg::OP_QUERY, ahm_pkg::LEAD_BYTE, 1'b1, 1'b0);
      // An empty word is stored and then found.
      push_req(ahm_pkg::OP_LOAD, 8'h20, 1'b1, 1'b0);
      push_req(ahm_pkg::OP_QUERY, 8'h00, 1'b1, 1'b0);
      // Query bytes that end on a load byte are stored; the ignored opcode
      // must not start an accent pair.
      push_req(ahm_pkg::OP_QUERY, ahm_pkg::LOWER_A, 1'b0, 1'b0);
      push_req(OP_UNUSED, ahm_pkg::LEAD_BYTE, 1'b1, 1'b0);
      push_req(ahm_pkg::OP_LOAD, ahm_pkg::LOWER_Z, 1'b1, 1'b0);
      // A clear in the middle of a word drops the word and the dictionary.
      push_req(ahm_pkg::OP_LOAD, ahm_pkg::LOWER_A, 1'b0, 1'b0);
      push_req(ahm_pkg::OP_CLEAR, ahm_pkg::LEAD_BYTE, 1'b1, 1'b0);
      push_req(ahm_pkg::OP_QUERY, ahm_pkg::LOWER_Z, 1'b1, 1'b0);

      stim_items = 0;
      while (stim_items < RANDOM_ITEMS) begin
         if (!full_done && stim_items > 300) begin
            // Fill the dictionary past its capacity with the same word, so
            // that a query sees every entry match.
            full_done = 1'b1;
            push_req(ahm_pkg::OP_CLEAR, 8'($urandom_range(0, 255)), 1'b0, 1'b1);
            repeat (ahm_pkg::DICT_WORDS + 2) begin
               push_req(ahm_pkg::OP_LOAD,
                        ($urandom_range(0, 1) != 0) ? ahm_pkg::UPPER_A : ahm_pkg::LOWER_A,
                        1'b1, 1'b0);
            end
            push_req(ahm_pkg::OP_QUERY, ahm_pkg::LOWER_A, 1'b1, 1'b0);
            push_req(ahm_pkg::OP_QUERY, ahm_pkg::LEAD_BYTE, 1'b0, 1'b0);
            push_req(ahm_pkg::OP_QUERY, 8'h81, 1'b1, 1'b0);
            push_req(ahm_pkg::OP_QUERY, ahm_pkg::LOWER_A + 8'd1, 1'b1, 1'b0);
            spell_word(random_word(), ahm_pkg::OP_QUERY, 1'b1, 1'b0);
            push_req(ahm_pkg::OP_CLEAR, 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)), 1'b0);
            dict_est = 0;
         end else if (!sat_done && stim_items > 650) begin
            // One word long enough to drive the 'a' bucket into saturation.
            sat_done = 1'b1;
            push_req(ahm_pkg::OP_CLEAR, 8'($urandom_range(0, 255)), 1'b0, 1'b0);
            push_req(ahm_pkg::OP_LOAD, ahm_pkg::LOWER_A + 8'd1, 1'b0, 1'b0);
            repeat (int'(ahm_pkg::COUNT_MAX) + 3) begin
               if ($urandom_range(0, 7) == 0) begin
                  push_req(ahm_pkg::OP_LOAD, ahm_pkg::LEAD_BYTE, 1'b0, 1'b0);
                  push_req(ahm_pkg::OP_LOAD, ($urandom_range(0, 1) != 0) ? 8'hA1 : 8'h81,
                           1'b0, 1'b0);
               end else begin
                  push_req(ahm_pkg::OP_LOAD,
                           ($urandom_range(0, 1) != 0) ? ahm_pkg::UPPER_A : ahm_pkg::LOWER_A,
                           1'b0, 1'b0);
               end
            end
            push_req(ahm_pkg::OP_LOAD, 8'h2E, 1'b1, 1'b0);
            push_req(ahm_pkg::OP_LOAD, ahm_pkg::UPPER_A + 8'd1, 1'b1, 1'b0);
            push_req(ahm_pkg::OP_QUERY, ahm_pkg::LOWER_A + 8'd1, 1'b1, 1'b0);
            push_req(ahm_pkg::OP_QUERY, ahm_pkg::LOWER_A, 1'b0, 1'b0);
            push_req(ahm_pkg::OP_QUERY, ahm_pkg::UPPER_A + 8'd1, 1'b1, 1'b0);
            dict_est = 2;
         end else begin
            hold = ($urandom_range(0, 5) == 0);
            if (dict_est > 40 || $urandom_range(0, 2) == 0) begin
               push_req(ahm_pkg::OP_CLEAR, 8'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1)), hold);
               hold = 1'b0;
               dict_est = 0;
            end
            nbank = $urandom_range(1, 6);
            for (k = 0; k < nbank; k++) begin
               bank[k] = random_word();
               spell_word(bank[k], ahm_pkg::OP_LOAD, 1'b1, hold);
               hold = 1'b0;
               dict_est++;
            end
            repeat ($urandom_range(1, 4)) begin
               case ($urandom_range(0, 9))
                  0:       w = '0;
                  1, 2, 3: w = random_word();
                  default: w = bank[$urandom_range(0, nbank - 1)];
               endcase
               spell_word(w, ahm_pkg::OP_QUERY, 1'b1, 1'b0);
            end
            // Now and then an unfinished word runs into the next one.
            if ($urandom_range(0, 7) == 0) begin
               spell_word(random_word(),
                          ($urandom_range(0, 1) != 0) ? ahm_pkg::OP_LOAD : ahm_pkg::OP_QUERY,
                          1'b0, 1'b0);
            end
         end
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (req_queue.size() != 0 || req_chan.valid) @(posedge clock);
      while (match_due.size() != 0) @(posedge clock);
      repeat (ahm_pkg::DICT_WORDS + 40) @(posedge clock);
      if (fail_count == 0 && match_due.size() == 0) begin
         $display("[anagram_histogram_matcher_top] OK");
      end else begin
         $display("[anagram_histogram_matcher_top] ERROR");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("[anagram_histogram_matcher_top] ERROR");
      $finish;
   end

endmodule
